@@ design/sprite_quad_setup_core_assert.svh @@
// ----------------------------------------------------------------------------
// Sprite quad setup: assertion macros
// Concurrent checks on clk_i with rst_ni, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_SETUP_CORE_ASSERT_SVH
`define SPRITE_QUAD_SETUP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SQS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sprite quad setup check failed");
`define SQS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sprite quad setup sequence check failed");
`else
`define SQS_ASSERT(name, prop)
`define SQS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ design/sqs_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite quad setup package
// Shared constants, codes, the job word passed from front to back, and helpers.
// ----------------------------------------------------------------------------
package sqs_pkg;

  localparam int CoordFracBits = 4;
  localparam int IndexBits     = 16;
  localparam int UvFracBits    = 16;
  localparam int AngleBits     = 16;
  localparam int QueueDepth    = 2;

  localparam logic [16:0] UvOne = 17'(1 << UvFracBits);

  typedef enum logic [2:0] {
    OP_XFORM     = 3'd0,
    OP_RECT_SRC  = 3'd1,
    OP_SRC_SIZED = 3'd2,
    OP_UNIT_UV   = 3'd3,
    OP_WHOLE_TEX = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CFG_COLOR = 3'd0,
    CFG_INV_W = 3'd1,
    CFG_INV_H = 3'd2,
    CFG_TEX_W = 3'd3,
    CFG_TEX_H = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CALC,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    op_e                op;
    logic signed [15:0] x0;
    logic signed [15:0] y0;
    logic signed [15:0] x2;
    logic signed [15:0] y2;
    logic signed [17:0] ofs_x;
    logic signed [17:0] ofs_y;
    logic [16:0]        zs;
    logic [16:0]        zc;
    logic               neg_s;
    logic               neg_c;
    logic signed [16:0] nox;
    logic signed [16:0] noy;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [15:0]        scx;
    logic [15:0]        scy;
    logic [16:0]        upix0;
    logic [16:0]        upix1;
    logic [16:0]        vpix0;
    logic [16:0]        vpix1;
  } job_t;

  typedef struct packed {
    logic                 busy;
    logic [IndexBits-1:0] base;
  } back_status_t;

  function automatic logic signed [15:0] sat_coord(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

endpackage

@@ design/sqs_front.sv @@
// ----------------------------------------------------------------------------
// Sprite quad setup: front end
// Accepts requests, drops unknown modes and prepares a job word: rectangle
// corners, sine arguments, pivot offsets and source pixel ends with flips.
// ----------------------------------------------------------------------------
module sqs_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] size_x_i,
  input  logic signed [15:0] size_y_i,
  input  logic signed [15:0] pivot_x_i,
  input  logic signed [15:0] pivot_y_i,
  input  logic [31:0]        src_origin_i,
  input  logic [31:0]        src_extent_i,
  input  logic [31:0]        scale_pair_i,
  input  logic [15:0]        angle_i,
  input  logic [1:0]         flips_i,
  input  logic [12:0]        tex_width_i,
  input  logic [12:0]        tex_height_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sqs_pkg::job_t      job_o
);

  logic               op_ok;
  logic [1:0]         fl_eff;
  logic signed [21:0] dx_w, dy_w, x2_w, y2_w;
  logic [16:0]        u_lo, u_hi, v_lo, v_hi, vs0, vs1;
  logic [15:0]        ang_c;

  // Quarter-wave argument: position inside the quadrant in Q16, mirrored on
  // odd quadrants.
  function automatic logic [16:0] sine_arg(input logic [sqs_pkg::AngleBits-1:0] a);
    logic [16:0] z;
    z = 17'(a[sqs_pkg::AngleBits-3:0]) << (18 - sqs_pkg::AngleBits);
    if (a[sqs_pkg::AngleBits-2]) begin
      z = 17'h10000 - z;
    end
    return z;
  endfunction

  assign op_ok      = op_i inside {[sqs_pkg::OP_XFORM:sqs_pkg::OP_WHOLE_TEX]};
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && op_ok;
  assign ang_c      = angle_i + 16'(1 << (sqs_pkg::AngleBits - 2));

  always_comb begin
    case (op_i)
      sqs_pkg::OP_SRC_SIZED: begin
        dx_w = $signed(22'(src_extent_i[15:0]) << sqs_pkg::CoordFracBits);
        dy_w = $signed(22'(src_extent_i[31:16]) << sqs_pkg::CoordFracBits);
      end
      sqs_pkg::OP_WHOLE_TEX: begin
        dx_w = $signed(22'(tex_width_i) << sqs_pkg::CoordFracBits);
        dy_w = $signed(22'(tex_height_i) << sqs_pkg::CoordFracBits);
      end
      default: begin
        dx_w = 22'(size_x_i);
        dy_w = 22'(size_y_i);
      end
    endcase
    x2_w = 22'(pos_x_i) + dx_w;
    y2_w = 22'(pos_y_i) + dy_w;

    u_lo = 17'(src_origin_i[15:0]);
    u_hi = 17'(src_origin_i[15:0]) + 17'(src_extent_i[15:0]);
    v_lo = 17'(src_origin_i[31:16]);
    v_hi = 17'(src_origin_i[31:16]) + 17'(src_extent_i[31:16]);

    // The transform mode runs V from the bottom of the source area upwards.
    if (op_i == sqs_pkg::OP_XFORM) begin
      vs0 = v_hi;
      vs1 = v_lo;
    end else begin
      vs0 = v_lo;
      vs1 = v_hi;
    end

    if (op_i == sqs_pkg::OP_XFORM || op_i == sqs_pkg::OP_RECT_SRC) begin
      fl_eff = flips_i;
    end else begin
      fl_eff = 2'b00;
    end

    job_o.op    = sqs_pkg::op_e'(op_i);
    job_o.x0    = pos_x_i;
    job_o.y0    = pos_y_i;
    job_o.x2    = sqs_pkg::sat_coord(32'(x2_w));
    job_o.y2    = sqs_pkg::sat_coord(32'(y2_w));
    job_o.ofs_x = 18'(pos_x_i) + 18'(pivot_x_i);
    job_o.ofs_y = 18'(pos_y_i) + 18'(pivot_y_i);
    job_o.zs    = sine_arg(angle_i);
    job_o.zc    = sine_arg(ang_c);
    job_o.neg_s = angle_i[sqs_pkg::AngleBits-1];
    job_o.neg_c = ang_c[sqs_pkg::AngleBits-1];
    job_o.nox   = -17'(pivot_x_i);
    job_o.noy   = -17'(pivot_y_i);
    job_o.dx    = 17'(size_x_i) - 17'(pivot_x_i);
    job_o.dy    = 17'(size_y_i) - 17'(pivot_y_i);
    job_o.scx   = scale_pair_i[15:0];
    job_o.scy   = scale_pair_i[31:16];
    job_o.upix0 = fl_eff[0] ? u_hi : u_lo;
    job_o.upix1 = fl_eff[0] ? u_lo : u_hi;
    job_o.vpix0 = fl_eff[1] ? vs1 : vs0;
    job_o.vpix1 = fl_eff[1] ? vs0 : vs1;
  end

endmodule

@@ design/sqs_queue.sv @@
// ----------------------------------------------------------------------------
// Sprite quad setup: job queue
// Short FIFO between the front and back ends so each can stall on its own.
// ----------------------------------------------------------------------------
module sqs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sqs_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sqs_pkg::job_t job_o
);

  localparam int PtrW = $clog2(sqs_pkg::QueueDepth);
  localparam int CntW = $clog2(sqs_pkg::QueueDepth + 1);

  sqs_pkg::job_t   slot_q [sqs_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(sqs_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ design/sqs_back.sv @@
// ----------------------------------------------------------------------------
// Sprite quad setup: back end
// Runs a job through the steps it needs (sine, scale, rotation, texture) of one
// shared registered multiplier, then sends four vertex and two triangle words.
// ----------------------------------------------------------------------------
module sqs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  sqs_pkg::job_t         job_i,
  input  logic [31:0]           color_i,
  input  logic [16:0]           inv_w_i,
  input  logic [16:0]           inv_h_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output logic signed [15:0]    vert_x_o,
  output logic signed [15:0]    vert_y_o,
  output logic [16:0]           tex_u_o,
  output logic [16:0]           tex_v_o,
  output logic [31:0]           color_out_o,
  output logic [15:0]           index_a_o,
  output logic [15:0]           index_b_o,
  output logic [15:0]           index_c_o,
  output logic                  last_o,
  output sqs_pkg::back_status_t status_o
);

  localparam logic [4:0] StepSin   = 5'd0;
  localparam logic [4:0] StepScale = 5'd8;
  localparam logic [4:0] StepRot   = 5'd12;
  localparam logic [4:0] StepUv    = 5'd20;
  localparam logic [4:0] StepLast  = 5'd23;
  localparam logic [2:0] EmitTriA  = 3'd4;
  localparam logic [2:0] EmitTriB  = 3'd5;
  localparam int         IdxW      = sqs_pkg::IndexBits;

  sqs_pkg::back_state_e state_q, state_d;
  sqs_pkg::job_t        job_q;
  logic [4:0]           step_q, wb_step_q;
  logic                 wb_vld_q;
  logic [2:0]           emit_q;
  logic [IdxW-1:0]      base_q;

  logic signed [25:0]   a_m;
  logic signed [17:0]   b_m;
  logic signed [43:0]   p_q;

  logic [16:0]          z2s_q, z2c_q, ts_q, tc_q;
  logic signed [17:0]   sn_q, cs_q;
  logic signed [25:0]   lx_q, ly_q, lx2_q, ly2_q;
  logic signed [43:0]   cs_lx_q, cs_lx2_q, sn_ly_q, sn_ly2_q;
  logic signed [43:0]   sn_lx_q, sn_lx2_q, cs_ly_q, cs_ly2_q;
  logic [16:0]          u_q, v_q, u2_q, v2_q;

  logic                 out_valid_q, out_load, use_x2, use_y2;
  logic signed [44:0]   rot_x, rot_y;
  logic signed [15:0]   vx, vy;
  logic [IdxW-1:0]      ia, ib, ic;

  assign out_load = (state_q == sqs_pkg::BK_EMIT) && (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    q_pop_o = 1'b0;
    case (state_q)
      sqs_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (job_i.op inside {sqs_pkg::OP_XFORM, sqs_pkg::OP_RECT_SRC,
                               sqs_pkg::OP_SRC_SIZED}) begin
            state_d = sqs_pkg::BK_CALC;
          end else begin
            state_d = sqs_pkg::BK_EMIT;
          end
        end
      end
      sqs_pkg::BK_CALC: begin
        if (step_q == StepLast) begin
          state_d = sqs_pkg::BK_EMIT;
        end
      end
      sqs_pkg::BK_EMIT: begin
        if (out_load && emit_q == EmitTriB) begin
          state_d = sqs_pkg::BK_IDLE;
        end
      end
      default: state_d = sqs_pkg::BK_IDLE;
    endcase
  end

  // Multiplier operands; each chain's result passes through the product register
  // and its write-back before use, so the sine and cosine chains are interleaved.
  always_comb begin
    case (step_q)
      StepSin:            begin a_m = 26'($signed({1'b0, job_q.zs})); b_m = $signed({1'b0, job_q.zs}); end
      StepSin + 5'd1:     begin a_m = 26'($signed({1'b0, job_q.zc})); b_m = $signed({1'b0, job_q.zc}); end
      StepSin + 5'd2:     begin a_m = 26'($signed({1'b0, z2s_q})); b_m = 18'sd4640; end
      StepSin + 5'd3:     begin a_m = 26'($signed({1'b0, z2c_q})); b_m = 18'sd4640; end
      StepSin + 5'd4:     begin a_m = 26'($signed({1'b0, z2s_q})); b_m = $signed({1'b0, ts_q}); end
      StepSin + 5'd5:     begin a_m = 26'($signed({1'b0, z2c_q})); b_m = $signed({1'b0, tc_q}); end
      StepSin + 5'd6:     begin a_m = 26'($signed({1'b0, job_q.zs})); b_m = $signed({1'b0, ts_q}); end
      StepSin + 5'd7:     begin a_m = 26'($signed({1'b0, job_q.zc})); b_m = $signed({1'b0, tc_q}); end
      StepScale:          begin a_m = 26'(job_q.nox); b_m = $signed({2'b0, job_q.scx}); end
      StepScale + 5'd1:   begin a_m = 26'(job_q.noy); b_m = $signed({2'b0, job_q.scy}); end
      StepScale + 5'd2:   begin a_m = 26'(job_q.dx);  b_m = $signed({2'b0, job_q.scx}); end
      StepScale + 5'd3:   begin a_m = 26'(job_q.dy);  b_m = $signed({2'b0, job_q.scy}); end
      StepRot:            begin a_m = lx_q;  b_m = cs_q; end
      StepRot + 5'd1:     begin a_m = lx2_q; b_m = cs_q; end
      StepRot + 5'd2:     begin a_m = ly_q;  b_m = sn_q; end
      StepRot + 5'd3:     begin a_m = ly2_q; b_m = sn_q; end
      StepRot + 5'd4:     begin a_m = lx_q;  b_m = sn_q; end
      StepRot + 5'd5:     begin a_m = lx2_q; b_m = sn_q; end
      StepRot + 5'd6:     begin a_m = ly_q;  b_m = cs_q; end
      StepRot + 5'd7:     begin a_m = ly2_q; b_m = cs_q; end
      StepUv:             begin a_m = 26'($signed({1'b0, job_q.upix0})); b_m = $signed({1'b0, inv_w_i}); end
      StepUv + 5'd1:      begin a_m = 26'($signed({1'b0, job_q.vpix0})); b_m = $signed({1'b0, inv_h_i}); end
      StepUv + 5'd2:      begin a_m = 26'($signed({1'b0, job_q.upix1})); b_m = $signed({1'b0, inv_w_i}); end
      default:            begin a_m = 26'($signed({1'b0, job_q.vpix1})); b_m = $signed({1'b0, inv_h_i}); end
    endcase
  end

  function automatic logic [16:0] uv_sat(input logic signed [43:0] p);
    if (p > 44'sd65536) begin
      return sqs_pkg::UvOne;
    end
    return 17'(p);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sqs_pkg::BK_IDLE;
      step_q      <= '0;
      wb_vld_q    <= 1'b0;
      wb_step_q   <= '0;
      emit_q      <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wb_vld_q  <= state_q == sqs_pkg::BK_CALC;
      wb_step_q <= step_q;
      if (q_pop_o) begin
        step_q <= (job_i.op == sqs_pkg::OP_XFORM) ? StepSin : StepUv;
        emit_q <= '0;
      end else if (state_q == sqs_pkg::BK_CALC) begin
        step_q <= 5'(step_q + 1'b1);
      end else if (out_load) begin
        emit_q <= 3'(emit_q + 1'b1);
      end
      if (out_load && emit_q == EmitTriB) begin
        base_q <= IdxW'(base_q + IdxW'(4));
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Job load, product register and write-back of each step.
  always_ff @(posedge clk_i) begin
    p_q <= a_m * b_m;
    if (q_pop_o) begin
      job_q <= job_i;
      u_q   <= '0;
      v_q   <= '0;
      u2_q  <= sqs_pkg::UvOne;
      v2_q  <= sqs_pkg::UvOne;
    end else if (wb_vld_q) begin
      case (wb_step_q)
        StepSin:          z2s_q <= 17'(p_q >>> 16);
        StepSin + 5'd1:   z2c_q <= 17'(p_q >>> 16);
        StepSin + 5'd2:   ts_q  <= 17'd42048 - 17'(p_q >>> 16);
        StepSin + 5'd3:   tc_q  <= 17'd42048 - 17'(p_q >>> 16);
        StepSin + 5'd4:   ts_q  <= 17'd102944 - 17'(p_q >>> 16);
        StepSin + 5'd5:   tc_q  <= 17'd102944 - 17'(p_q >>> 16);
        StepSin + 5'd6:   sn_q  <= job_q.neg_s ? -18'(p_q >>> 16) : 18'(p_q >>> 16);
        StepSin + 5'd7:   cs_q  <= job_q.neg_c ? -18'(p_q >>> 16) : 18'(p_q >>> 16);
        StepScale:        lx_q  <= 26'((p_q + 44'sd128) >>> 8);
        StepScale + 5'd1: ly_q  <= 26'((p_q + 44'sd128) >>> 8);
        StepScale + 5'd2: lx2_q <= 26'((p_q + 44'sd128) >>> 8);
        StepScale + 5'd3: ly2_q <= 26'((p_q + 44'sd128) >>> 8);
        StepRot:          cs_lx_q  <= p_q;
        StepRot + 5'd1:   cs_lx2_q <= p_q;
        StepRot + 5'd2:   sn_ly_q  <= p_q;
        StepRot + 5'd3:   sn_ly2_q <= p_q;
        StepRot + 5'd4:   sn_lx_q  <= p_q;
        StepRot + 5'd5:   sn_lx2_q <= p_q;
        StepRot + 5'd6:   cs_ly_q  <= p_q;
        StepRot + 5'd7:   cs_ly2_q <= p_q;
        StepUv:           u_q  <= uv_sat(p_q);
        StepUv + 5'd1:    v_q  <= uv_sat(p_q);
        StepUv + 5'd2:    u2_q <= uv_sat(p_q);
        default:          v2_q <= uv_sat(p_q);
      endcase
    end
  end

  // Corner selection: corners run (x,y) (x,y2) (x2,y2) (x2,y).
  always_comb begin
    use_x2 = emit_q[1];
    use_y2 = emit_q[1] ^ emit_q[0];
    rot_x  = 45'(use_x2 ? cs_lx2_q : cs_lx_q) - 45'(use_y2 ? sn_ly2_q : sn_ly_q)
             + 45'sd32768;
    rot_y  = 45'(use_x2 ? sn_lx2_q : sn_lx_q) + 45'(use_y2 ? cs_ly2_q : cs_ly_q)
             + 45'sd32768;
    if (job_q.op == sqs_pkg::OP_XFORM) begin
      vx = sqs_pkg::sat_coord(32'(rot_x >>> 16) + 32'(job_q.ofs_x));
      vy = sqs_pkg::sat_coord(32'(rot_y >>> 16) + 32'(job_q.ofs_y));
    end else begin
      vx = use_x2 ? job_q.x2 : job_q.x0;
      vy = use_y2 ? job_q.y2 : job_q.y0;
    end
    if (emit_q == EmitTriA) begin
      ia = base_q;
      ib = IdxW'(base_q + IdxW'(1));
      ic = IdxW'(base_q + IdxW'(2));
    end else begin
      ia = IdxW'(base_q + IdxW'(2));
      ib = IdxW'(base_q + IdxW'(3));
      ic = base_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (emit_q < EmitTriA) begin
        kind_o      <= 1'b0;
        vert_x_o    <= vx;
        vert_y_o    <= vy;
        tex_u_o     <= use_x2 ? u2_q : u_q;
        tex_v_o     <= use_y2 ? v2_q : v_q;
        color_out_o <= color_i;
        index_a_o   <= '0;
        index_b_o   <= '0;
        index_c_o   <= '0;
        last_o      <= 1'b0;
      end else begin
        kind_o      <= 1'b1;
        vert_x_o    <= '0;
        vert_y_o    <= '0;
        tex_u_o     <= '0;
        tex_v_o     <= '0;
        color_out_o <= '0;
        index_a_o   <= 16'(ia);
        index_b_o   <= 16'(ib);
        index_c_o   <= 16'(ic);
        last_o      <= emit_q == EmitTriB;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o.busy = state_q != sqs_pkg::BK_IDLE;
  assign status_o.base = base_q;

endmodule

@@ design/sprite_quad_setup_core.sv @@
// ----------------------------------------------------------------------------
// Sprite quad setup core
// Each sprite passes through the queue into the shared multiplier sequence
// (24 steps for transform sprites, 4 for source-area rectangles, none for
// unit-UV and whole-texture), then six result words at one per cycle unless
// the output stalls; the next job leaves the queue once the last word loads.
// Reset clears the vertex base, the queue, the configuration registers and all handshakes.
// ----------------------------------------------------------------------------
`include "sprite_quad_setup_core_assert.svh"

module sprite_quad_setup_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] size_x_i,
  input  logic signed [15:0] size_y_i,
  input  logic signed [15:0] pivot_x_i,
  input  logic signed [15:0] pivot_y_i,
  input  logic [31:0]        src_origin_i,
  input  logic [31:0]        src_extent_i,
  input  logic [31:0]        scale_pair_i,
  input  logic [15:0]        angle_i,
  input  logic [1:0]         flips_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic signed [15:0] vert_x_o,
  output logic signed [15:0] vert_y_o,
  output logic [16:0]        tex_u_o,
  output logic [16:0]        tex_v_o,
  output logic [31:0]        color_out_o,
  output logic [15:0]        index_a_o,
  output logic [15:0]        index_b_o,
  output logic [15:0]        index_c_o,
  output logic               last_o
);

  logic [31:0] color_q;
  logic [16:0] inv_w_q, inv_h_q;
  logic [12:0] tex_w_q, tex_h_q;

  logic                  q_push, q_pop, q_full, q_empty;
  sqs_pkg::job_t         job_in, job_out;
  sqs_pkg::back_status_t bk_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
      inv_w_q <= '0;
      inv_h_q <= '0;
      tex_w_q <= '0;
      tex_h_q <= '0;
    end else if (cfg_we_i) begin
      case (sqs_pkg::cfg_idx_e'(cfg_idx_i))
        sqs_pkg::CFG_COLOR: color_q <= cfg_wdata_i;
        sqs_pkg::CFG_INV_W: inv_w_q <= cfg_wdata_i[16:0];
        sqs_pkg::CFG_INV_H: inv_h_q <= cfg_wdata_i[16:0];
        sqs_pkg::CFG_TEX_W: tex_w_q <= cfg_wdata_i[12:0];
        sqs_pkg::CFG_TEX_H: tex_h_q <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  sqs_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .size_x_i     (size_x_i),
    .size_y_i     (size_y_i),
    .pivot_x_i    (pivot_x_i),
    .pivot_y_i    (pivot_y_i),
    .src_origin_i (src_origin_i),
    .src_extent_i (src_extent_i),
    .scale_pair_i (scale_pair_i),
    .angle_i      (angle_i),
    .flips_i      (flips_i),
    .tex_width_i  (tex_w_q),
    .tex_height_i (tex_h_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .job_o        (job_in)
  );

  sqs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (job_out)
  );

  sqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .job_i       (job_out),
    .color_i     (color_q),
    .inv_w_i     (inv_w_q),
    .inv_h_i     (inv_h_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .vert_x_o    (vert_x_o),
    .vert_y_o    (vert_y_o),
    .tex_u_o     (tex_u_o),
    .tex_v_o     (tex_v_o),
    .color_out_o (color_out_o),
    .index_a_o   (index_a_o),
    .index_b_o   (index_b_o),
    .index_c_o   (index_c_o),
    .last_o      (last_o),
    .status_o    (bk_status)
  );

  // The back end only takes a job that the queue holds.
  `SQS_ASSERT(a_pop_nonempty, q_pop |-> !q_empty)
  // Once the closing triangle word is loaded, the base has moved on by four.
  `SQS_ASSERT(a_base_step, out_valid_o && last_o |-> bk_status.base == 16'(index_c_o + 16'd4))
  // Taking a job always leaves the back end busy in the next cycle.
  `SQS_ASSERT_NEXT(a_busy_after_pop, q_pop, bk_status.busy)

endmodule
